// File: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the H-bridge PWM scheduler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising edge of clk, switched off while rst is high.
`define HBP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check on the rising edge of clk that also holds during reset.
`define HBP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/hbp_pkg.sv
// Shared widths, register indexes, reset values and types of the H-bridge PWM scheduler.
`default_nettype none

package hbp_pkg;

  // Field widths of the channels and of the configuration registers.
  localparam int CMD_W      = 16;
  localparam int SUP_W      = 12;
  localparam int PORT_W     = 8;
  localparam int TIME_W     = 16;
  localparam int DEAD_W     = 8;
  localparam int MIN_W      = 10;
  localparam int DITH_W     = 8;
  localparam int LFSR_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  // Intermediate width that holds a period of up to full scale plus margin.
  localparam int WIDE_W     = 17;
  localparam int FULL_SCALE = 32768;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BRIDGE_ENABLE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL_SUPPLY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_TIME      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DUTY       = 2'd3;

  // Reset values of the configuration registers. The nominal supply is
  // 6 V on a 4095-count scale whose full range is 23.739 V.
  localparam logic [SUP_W-1:0] NOMINAL_RESET  = SUP_W'(6000 * 4095 / 23739);
  localparam logic [DEAD_W-1:0] DEAD_RESET    = 8'd10;
  localparam logic [MIN_W-1:0] MIN_DUTY_RESET = 10'd256;

  // Dither level that lets every cycle switch.
  localparam logic [DITH_W-1:0] DITHER_FULL = 8'd255;

  // Dither generator seed and feedback taps.
  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hA1A1;
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hA1A1;

  // Bridge pins under watch and the two legal diagonal patterns.
  localparam logic [PORT_W-1:0] PIN_MASK   = 8'hC6;
  localparam logic [PORT_W-1:0] PIN_DIAG_A = 8'hC0;
  localparam logic [PORT_W-1:0] PIN_DIAG_B = 8'h06;

  // Status of the shared divider as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } hbp_div_status_t;

endpackage

`default_nettype wire

// File: rtl/hbp_item_if.sv
// Input channel of the H-bridge PWM scheduler: commands and half-period ticks.
`default_nettype none

interface hbp_item_if;
  import hbp_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     op;
  logic signed [CMD_W-1:0]  command;
  logic        [SUP_W-1:0]  supply_voltage;
  logic        [PORT_W-1:0] port_state;

  modport source (output valid, output op, output command, output supply_voltage,
                  output port_state, input ready);
  modport sink   (input valid, input op, input command, input supply_voltage,
                  input port_state, output ready);
endinterface

`default_nettype wire

// File: rtl/hbp_result_if.sv
// Result channel of the H-bridge PWM scheduler: one beat per input item.
`default_nettype none

interface hbp_result_if;
  import hbp_pkg::*;

  logic              valid;
  logic              ready;
  logic              accepted;
  logic [TIME_W-1:0] q1_compare;
  logic [TIME_W-1:0] q2_compare;
  logic [TIME_W-1:0] q3_compare;
  logic [TIME_W-1:0] q4_compare;
  logic [TIME_W-1:0] tick_compare;
  logic              driver_on;
  logic              fault;

  modport source (output valid, output accepted, output q1_compare, output q2_compare,
                  output q3_compare, output q4_compare, output tick_compare,
                  output driver_on, output fault, input ready);
  modport sink   (input valid, input accepted, input q1_compare, input q2_compare,
                  input q3_compare, input q4_compare, input tick_compare,
                  input driver_on, input fault, output ready);
endinterface

`default_nettype wire

// File: rtl/hbp_cfg_if.sv
// Configuration write channel of the H-bridge PWM scheduler.
`default_nettype none

interface hbp_cfg_if;
  import hbp_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/hbp_div.sv
// Shared restoring divider, one quotient bit per clock.
`default_nettype none

module hbp_div #(
  parameter int NW  = 24,
  parameter int DVW = 12
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [NW-1:0]            dividend,
  input  logic [DVW-1:0]           divisor,
  output hbp_pkg::hbp_div_status_t status,
  output logic [NW-1:0]            quotient
);
  import hbp_pkg::*;

  localparam int CW = $clog2(NW + 1);

  logic [DVW-1:0] rem;
  logic [NW-1:0]  quo;
  logic [CW-1:0]  count;
  logic           busy;
  logic           done;
  logic [DVW:0]   trial;
  logic           fits;

  // Bring down the next dividend bit and try the subtraction.
  assign trial = {rem, quo[NW-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      // Done pulses for one cycle after the last quotient bit.
      done <= !start && busy && (count == CW'(1));
      if (start) begin
        busy  <= 1'b1;
        count <= CW'(NW);
      end else if (busy) begin
        count <= count - CW'(1);
        if (count == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? DVW'(trial - {1'b0, divisor}) : DVW'(trial);
      quo <= {quo[NW-2:0], fits};
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign quotient    = quo;

endmodule

`default_nettype wire

// File: rtl/h_bridge_pwm_scheduler.sv
// Top level of the H-bridge center-aligned PWM scheduler with dead time.
`default_nettype none

// The scheduler turns signed drive commands into center-aligned switch
// compare times for a four-switch H bridge (Q1/Q2 left leg, Q3/Q4 right
// leg). A command beat (op 0) is taken as pending when no command is
// already pending; it yields a direction, an upper-switch duty and a
// lower-switch duty of the uncorrected duty plus the dead time, with the
// upper duty reduced when the supply is above nominal and short pulses
// stretched to the minimum duty and dithered. A tick beat (op 1) arrives
// every half PWM period: it returns the compare times scheduled by the
// previous tick, checks the bridge pins, latches the pending command at
// the second half and schedules the next edges. An illegal pin pattern
// returns every piece of scheduler state to its reset value and turns
// the driver off; the configuration registers keep their values. Every
// item gives exactly one result beat. An accepted command has its demand
// scaled to timer counts by a reciprocal multiplication; when the supply
// is above nominal, the supply correction takes one pass through the
// shared bit-serial divider over the duty-times-excess product. A command
// that finds another one pending is answered with accepted low. A result
// that waits for the receiver holds the sequencer in its last state for
// as long as it waits. The input is taken one item at a time while the
// previous result may still wait in the output register. Configuration
// writes are always ready.
module h_bridge_pwm_scheduler #(
  parameter int PWM_PERIOD = 2048
) (
  input  logic         clk,
  input  logic         rst,
  hbp_item_if.sink     item,
  hbp_result_if.source result,
  hbp_cfg_if.sink      cfg
);
  import hbp_pkg::*;

  // Duty values never exceed the period.
  localparam int DW      = $clog2(PWM_PERIOD + 1);
  // Product of a duty and a supply difference.
  localparam int PW      = DW + SUP_W;
  // Command counts per timer count.
  localparam int DIVISOR = FULL_SCALE / PWM_PERIOD;
  // Reciprocal of the divisor, rounded up, exact for every magnitude that
  // fits in WIDE_W bits.
  localparam int RECIP_SH = WIDE_W + $clog2(DIVISOR);
  localparam int RECIP    = ((1 << RECIP_SH) + DIVISOR - 1) / DIVISOR;
  localparam int RECIP_W  = WIDE_W + 1;
  localparam int SCALE_W  = WIDE_W + RECIP_W;

  localparam logic [WIDE_W-1:0]  PERIOD_W     = WIDE_W'(PWM_PERIOD);
  localparam logic [WIDE_W-1:0]  CMD_WRAP     = WIDE_W'(1) << CMD_W;
  localparam logic [TIME_W-1:0]  PERIOD_T     = TIME_W'(PWM_PERIOD);
  localparam logic [TIME_W-1:0]  HALF_FIRST   = TIME_W'(PWM_PERIOD / 2);
  localparam logic [TIME_W-1:0]  HALF_SECOND  = TIME_W'(PWM_PERIOD - PWM_PERIOD / 2);
  localparam logic [TIME_W-1:0]  SWITCH_RESET = TIME_W'(PWM_PERIOD / 2 - 1);
  localparam logic [RECIP_W-1:0] RECIP_C      = RECIP_W'(RECIP);

  // Sequencer states.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_TICK  = 4'd1;
  localparam logic [3:0] S_REJ   = 4'd2;
  localparam logic [3:0] S_SCALE = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_DGO   = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_FIN   = 4'd7;

  // Offset from the period start to the first edge of a centered pulse.
  function automatic logic [TIME_W-1:0] half_gap(input logic [DW-1:0] duty);
    logic [WIDE_W-1:0] gap;
    gap = PERIOD_W - WIDE_W'(duty);
    return (WIDE_W'(duty) >= PERIOD_W) ? '0 : TIME_W'(gap >> 1);
  endfunction

  // Control and configuration.
  logic [3:0]        state;
  logic              res_valid;
  logic              bridge_enable;
  logic [SUP_W-1:0]  nominal_supply;
  logic [DEAD_W-1:0] dead_time;
  logic [MIN_W-1:0]  min_duty;

  // Latched input beat and working registers of a command.
  logic [CMD_W-1:0]  in_cmd;
  logic [SUP_W-1:0]  in_uin;
  logic [PORT_W-1:0] in_port;
  logic [DW-1:0]     value;
  logic [DW-1:0]     corr;
  logic [PW-1:0]     prod;

  // Scheduler state.
  logic              pending_direction;
  logic [DW-1:0]     pending_pos_duty;
  logic [DW-1:0]     pending_neg_duty;
  logic [DITH_W-1:0] pending_dither;
  logic              pending_valid;
  logic              live_direction;
  logic [DW-1:0]     live_pos_duty;
  logic [DW-1:0]     live_neg_duty;
  logic [DITH_W-1:0] live_dither;
  logic              half_phase;
  logic              cycle_active;
  logic [TIME_W-1:0] tick_time;
  logic [TIME_W-1:0] switch_time [4];
  logic [LFSR_W-1:0] dither_lfsr;
  logic              driver_level;

  // Result register payload.
  logic              res_accepted;
  logic [TIME_W-1:0] res_switch [4];
  logic [TIME_W-1:0] res_tick;
  logic              res_driver_on;
  logic              res_fault;

  // Shared divider.
  hbp_div_status_t   div_stat;
  logic              div_start;
  logic [PW-1:0]     div_dividend;
  logic [SUP_W-1:0]  div_divisor;
  logic [PW-1:0]     div_q;

  logic out_free;
  logic tick_commit;
  logic set_commit;
  logic rej_commit;
  logic sched_clear;

  assign out_free    = !res_valid || result.ready;
  assign tick_commit = (state == S_TICK) && out_free;
  assign set_commit  = (state == S_FIN) && out_free;
  assign rej_commit  = (state == S_REJ) && out_free;

  assign item.ready = (state == S_IDLE);
  assign cfg.ready  = 1'b1;

  // ---------------------------------------------------------------------
  // Command arithmetic
  // ---------------------------------------------------------------------
  // The most negative command has magnitude full scale.
  logic [WIDE_W-1:0]  mag;
  logic [SCALE_W-1:0] scaled_prod;
  logic [WIDE_W-1:0]  scaled;
  logic [WIDE_W-1:0]  floor_sum;
  logic [WIDE_W-1:0]  lim;
  logic [SUP_W-1:0]   supply_excess;
  logic               compensate;

  assign mag           = in_cmd[CMD_W-1] ? (CMD_WRAP - WIDE_W'(in_cmd)) : WIDE_W'(in_cmd);
  // Demand in timer counts: multiply by the rounded-up reciprocal and keep
  // the integer part.
  assign scaled_prod   = SCALE_W'(mag) * SCALE_W'(RECIP_C);
  assign scaled        = WIDE_W'(scaled_prod >> RECIP_SH);
  assign floor_sum     = WIDE_W'(min_duty) + WIDE_W'(dead_time);
  // Longest upper-switch duty; it saturates at zero when the minimum duty
  // plus dead time do not fit in the period.
  assign lim           = (floor_sum >= PERIOD_W) ? '0 : PERIOD_W - floor_sum;
  assign compensate    = in_uin > nominal_supply;
  assign supply_excess = in_uin - nominal_supply;

  assign div_start    = (state == S_DGO);
  assign div_dividend = prod;
  assign div_divisor  = in_uin;

  hbp_div #(
    .NW  (PW),
    .DVW (SUP_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .status   (div_stat),
    .quotient (div_q)
  );

  // Final duties of a command once the correction is known.
  logic [WIDE_W-1:0] val_w;
  logic [WIDE_W-1:0] corr_w;
  logic [WIDE_W-1:0] pos_raw;
  logic [WIDE_W-1:0] neg_raw;
  logic [WIDE_W-1:0] fin_pos;
  logic [WIDE_W-1:0] fin_neg;
  logic [DITH_W-1:0] fin_dither;

  always_comb begin
    val_w      = WIDE_W'(value);
    corr_w     = WIDE_W'(corr);
    pos_raw    = val_w - corr_w;
    neg_raw    = val_w + WIDE_W'(dead_time);
    fin_dither = DITHER_FULL;
    priority if (val_w <= corr_w) begin
      // The correction eats the whole pulse: no switching at all.
      fin_pos = '0;
      fin_neg = '0;
    end else if (pos_raw < WIDE_W'(min_duty)) begin
      // Short pulse: stretch it and let the dither gate thin it out.
      fin_dither = (pos_raw < WIDE_W'(DITHER_FULL)) ? DITH_W'(pos_raw) : DITHER_FULL;
      fin_pos    = WIDE_W'(min_duty);
      fin_neg    = (neg_raw < floor_sum) ? floor_sum : neg_raw;
    end else begin
      fin_pos = pos_raw;
      fin_neg = neg_raw;
    end
  end

  // ---------------------------------------------------------------------
  // Tick scheduling
  // ---------------------------------------------------------------------
  logic [PORT_W-1:0] pins;
  logic              tick_bad;
  logic              eff_direction;
  logic [DW-1:0]     eff_pos;
  logic [DW-1:0]     eff_neg;
  logic [DITH_W-1:0] eff_dither;
  logic [LFSR_W-1:0] lfsr_next;
  logic [DITH_W-1:0] rnd;
  logic              draw;
  logic              start_cycle;
  logic              place_en;
  logic              place_dir;
  logic [TIME_W-1:0] pos_time;
  logic [TIME_W-1:0] neg_time;
  logic [TIME_W-1:0] base_time;
  logic [TIME_W-1:0] sw_next [4];

  always_comb begin
    pins     = in_port & PIN_MASK;
    // Any driven pin in the first half is illegal; in the second half only
    // one full diagonal may be on.
    tick_bad = (pins != '0) &&
               (!half_phase || ((pins != PIN_DIAG_A) && (pins != PIN_DIAG_B)));

    // The pending command takes effect at the start of a new PWM cycle.
    if (half_phase && pending_valid) begin
      eff_direction = pending_direction;
      eff_pos       = pending_pos_duty;
      eff_neg       = pending_neg_duty;
      eff_dither    = pending_dither;
    end else begin
      eff_direction = live_direction;
      eff_pos       = live_pos_duty;
      eff_neg       = live_neg_duty;
      eff_dither    = live_dither;
    end

    lfsr_next = (dither_lfsr >> 1) ^ (dither_lfsr[0] ? LFSR_TAPS : '0);
    rnd       = (lfsr_next[DITH_W-1:0] != '0) ? lfsr_next[DITH_W-1:0] : DITH_W'(1);
    // The generator only steps when the dither gate is actually consulted.
    draw        = bridge_enable && (eff_pos != '0);
    start_cycle = draw && (rnd <= eff_dither);

    base_time = tick_time - TIME_W'(1);
    if (half_phase) begin
      place_en  = start_cycle;
      place_dir = eff_direction;
      pos_time  = tick_time + half_gap(eff_pos);
      neg_time  = tick_time + half_gap(eff_neg);
    end else begin
      place_en  = cycle_active;
      place_dir = live_direction;
      pos_time  = tick_time + TIME_W'(live_pos_duty >> 1);
      neg_time  = tick_time + TIME_W'(live_neg_duty >> 1);
    end

    // Direction 0 switches the left leg, direction 1 the right leg.
    sw_next[0] = (place_en && !place_dir) ? pos_time : base_time;
    sw_next[1] = (place_en && !place_dir) ? neg_time : base_time;
    sw_next[2] = (place_en && place_dir) ? pos_time : base_time;
    sw_next[3] = (place_en && place_dir) ? neg_time : base_time;
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      // A new result replaces one that leaves at the same edge.
      if (tick_commit || set_commit || rej_commit) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item.valid) begin
            priority if (item.op) begin
              state <= S_TICK;
            end else if (pending_valid) begin
              state <= S_REJ;
            end else begin
              state <= S_SCALE;
            end
          end
        end
        S_TICK, S_REJ, S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_SCALE: state <= S_MUL;
        S_MUL: state <= compensate ? S_DGO : S_FIN;
        S_DGO: state <= S_DIV;
        S_DIV: begin
          if (div_stat.done) begin
            state <= S_FIN;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Input beat and command working registers.
  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_cmd  <= CMD_W'(item.command);
      in_uin  <= item.supply_voltage;
      in_port <= item.port_state;
    end
    if (state == S_SCALE) begin
      value <= (scaled > lim) ? DW'(lim) : DW'(scaled);
    end
    if (state == S_MUL) begin
      prod <= PW'(value) * PW'(supply_excess);
      corr <= '0;
    end
    if ((state == S_DIV) && div_stat.done) begin
      corr <= DW'(div_q);
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      bridge_enable  <= 1'b0;
      nominal_supply <= NOMINAL_RESET;
      dead_time      <= DEAD_RESET;
      min_duty       <= MIN_DUTY_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        CFG_BRIDGE_ENABLE:  bridge_enable  <= cfg.data[0];
        CFG_NOMINAL_SUPPLY: nominal_supply <= cfg.data[SUP_W-1:0];
        CFG_DEAD_TIME:      dead_time      <= cfg.data[DEAD_W-1:0];
        CFG_MIN_DUTY:       min_duty       <= cfg.data[MIN_W-1:0];
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Scheduler state: cleared by reset and by a pin fault
  // ---------------------------------------------------------------------
  assign sched_clear = rst || (tick_commit && tick_bad);

  always_ff @(posedge clk) begin
    if (sched_clear) begin
      pending_direction <= 1'b0;
      pending_pos_duty  <= '0;
      pending_neg_duty  <= '0;
      pending_dither    <= '0;
      pending_valid     <= 1'b0;
      live_direction    <= 1'b0;
      live_pos_duty     <= '0;
      live_neg_duty     <= '0;
      live_dither       <= DITHER_FULL;
      half_phase        <= 1'b0;
      cycle_active      <= 1'b0;
      tick_time         <= PERIOD_T;
      for (int i = 0; i < 4; i++) begin
        switch_time[i] <= SWITCH_RESET;
      end
      dither_lfsr       <= LFSR_SEED;
      driver_level      <= 1'b0;
    end else if (tick_commit) begin
      for (int i = 0; i < 4; i++) begin
        switch_time[i] <= sw_next[i];
      end
      if (half_phase) begin
        // Start of a new PWM cycle.
        if (pending_valid) begin
          live_direction <= pending_direction;
          live_pos_duty  <= pending_pos_duty;
          live_neg_duty  <= pending_neg_duty;
          live_dither    <= pending_dither;
          pending_valid  <= 1'b0;
        end
        if (draw) begin
          dither_lfsr <= lfsr_next;
        end
        driver_level <= bridge_enable;
        cycle_active <= start_cycle;
        tick_time    <= tick_time + HALF_FIRST;
        half_phase   <= 1'b0;
      end else begin
        tick_time  <= tick_time + HALF_SECOND;
        half_phase <= 1'b1;
      end
    end else if (set_commit) begin
      pending_direction <= in_cmd[CMD_W-1];
      pending_pos_duty  <= DW'(fin_pos);
      pending_neg_duty  <= DW'(fin_neg);
      pending_dither    <= fin_dither;
      pending_valid     <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (tick_commit) begin
      res_accepted  <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        res_switch[i] <= switch_time[i];
      end
      res_tick      <= tick_time;
      res_driver_on <= !tick_bad && (half_phase ? bridge_enable : driver_level);
      res_fault     <= tick_bad;
    end else if (set_commit || rej_commit) begin
      res_accepted  <= set_commit;
      for (int i = 0; i < 4; i++) begin
        res_switch[i] <= '0;
      end
      res_tick      <= '0;
      res_driver_on <= driver_level;
      res_fault     <= 1'b0;
    end
  end

  assign result.valid        = res_valid;
  assign result.accepted     = res_accepted;
  assign result.q1_compare   = res_switch[0];
  assign result.q2_compare   = res_switch[1];
  assign result.q3_compare   = res_switch[2];
  assign result.q4_compare   = res_switch[3];
  assign result.tick_compare = res_tick;
  assign result.driver_on    = res_driver_on;
  assign result.fault        = res_fault;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
`include "assert_macros.svh"

  `HBP_ASSERT(a_div_in_div_state, div_stat.busy |-> (state == S_DIV),
              "divider runs outside the divide state")
  `HBP_ASSERT(a_pending_from_cmd, $rose(pending_valid) |-> $past(state) == S_FIN,
              "pending command set without a finished command")
  `HBP_ASSERT(a_fault_clears,
              (tick_commit && tick_bad) |=>
                (!pending_valid && !driver_level && !half_phase && tick_time == PERIOD_T),
              "pin fault did not clear the scheduler")
  `HBP_ASSERT(a_phase_toggles,
              (tick_commit && !tick_bad) |=> half_phase != $past(half_phase),
              "half phase did not advance on a tick")
  `HBP_ASSERT_ALWAYS(a_reset_idle, rst |=> (state == S_IDLE && !res_valid),
                     "reset did not return the sequencer to idle")

endmodule

`default_nettype wire

// File: verif/h_bridge_pwm_scheduler_test.sv
// Self-checking testbench of the H-bridge PWM scheduler: random and directed beats.
`timescale 1ns / 100ps

module h_bridge_pwm_scheduler_test;
  import hbp_pkg::*;

  localparam int PWM_PERIOD = 2048;

  // Item kinds on the input channel.
  localparam bit OP_SET  = 1'b0;
  localparam bit OP_TICK = 1'b1;

  // Cycles to let pass after the last result, covering the slowest command.
  localparam int DRAIN_CYCLES = 80;

  // One input beat as the driver presents it.
  typedef struct packed {
    bit              op;
    bit [CMD_W-1:0]  command;
    bit [SUP_W-1:0]  supply;
    bit [PORT_W-1:0] port;
  } drive_item_t;

  // One result beat as the scheduler should return it.
  typedef struct packed {
    bit              accepted;
    bit [TIME_W-1:0] q1, q2, q3, q4, tick;
    bit              driver_on;
    bit              fault;
  } bridge_out_t;

  logic clk;
  logic rst;

  hbp_item_if   item_bus ();
  hbp_result_if result_bus ();
  hbp_cfg_if    cfg_bus ();

  h_bridge_pwm_scheduler #(
    .PWM_PERIOD(PWM_PERIOD)
  ) u_dut (
    .clk   (clk),
    .rst   (rst),
    .item  (item_bus),
    .result(result_bus),
    .cfg   (cfg_bus)
  );

  // Beats waiting to be offered, and the compare times due back, oldest first.
  drive_item_t items_to_send[$];
  bridge_out_t bridge_outputs_due[$];
  drive_item_t in_flight;

  int items_queued   = 0;
  int items_sent     = 0;
  int results_seen   = 0;
  int mismatch_count = 0;

  // The generator keeps its own idea of the half phase so that it can put
  // legal pin patterns on the ticks; it follows faults the same way.
  bit gen_phase;

  // Receiver hold-off: a long stretch with ready low, counted below.
  int hold_left;
  int next_hold_at;

  // ---------------------------------------------------------------------
  // Scheduler state as the checker sees it.
  // ---------------------------------------------------------------------
  bit              motor_en;
  bit [SUP_W-1:0]  nom_supply;
  bit [DEAD_W-1:0] dead_cnt;
  bit [MIN_W-1:0]  min_pulse;

  // Command waiting for the next second-half tick.
  bit next_dir, next_held;
  int next_pos, next_neg, next_dith;
  // Command that the switching cycles use now.
  bit run_dir;
  int run_pos, run_neg, run_dith;

  bit              second_half;
  bit              switching;
  bit [TIME_W-1:0] tick_at;
  bit [TIME_W-1:0] edge_at[4];
  bit [LFSR_W-1:0] dither_reg;
  bit              drv_level;

  // State after reset and after a pin fault; the registers are left alone.
  function automatic void clear_bridge();
    next_dir    = 1'b0;
    next_pos    = 0;
    next_neg    = 0;
    next_dith   = 0;
    next_held   = 1'b0;
    run_dir     = 1'b0;
    run_pos     = 0;
    run_neg     = 0;
    run_dith    = DITHER_FULL;
    second_half = 1'b0;
    switching   = 1'b0;
    tick_at     = TIME_W'(PWM_PERIOD);
    foreach (edge_at[i]) edge_at[i] = TIME_W'(PWM_PERIOD / 2 - 1);
    dither_reg  = LFSR_SEED;
    drv_level   = 1'b0;
  endfunction

  // Offset that centers a pulse of the given length in the period.
  function automatic int half_gap(int duty);
    return (duty >= PWM_PERIOD) ? 0 : (PWM_PERIOD - duty) / 2;
  endfunction

  // Applies one accepted beat to the state above and returns the result
  // beat that the scheduler owes for it.
  function automatic bridge_out_t advance_bridge(drive_item_t it);
    bridge_out_t     o;
    bit [PORT_W-1:0] pins;
    bit [TIME_W-1:0] base;
    bit [DITH_W-1:0] draw;
    bit              lsb;
    int              demand, duty, limit, trim, hi;
    o = '0;

    if (it.op == OP_SET) begin
      // A command that finds one pending is dropped; its result beat has accepted low.
      if (!next_held) begin
        next_dir = it.command[CMD_W-1];
        // The most negative demand has a magnitude of full scale.
        demand = next_dir ? 65536 - int'(it.command) : int'(it.command);
        duty = demand / (FULL_SCALE / PWM_PERIOD);
        limit = PWM_PERIOD - int'(min_pulse) - int'(dead_cnt);
        if (limit < 0) limit = 0;
        if (duty > limit) duty = limit;
        // Above the nominal supply the duty shrinks by (u - nom) / u.
        trim = 0;
        if (it.supply > nom_supply)
          trim = duty * (int'(it.supply) - int'(nom_supply)) / int'(it.supply);
        next_dith = DITHER_FULL;
        if (duty <= trim) begin
          next_pos = 0;
          next_neg = 0;
        end else begin
          next_pos = duty - trim;
          next_neg = duty + int'(dead_cnt);
          // A short pulse runs at minimum duty, on a share of cycles only.
          if (next_pos < int'(min_pulse)) begin
            next_dith = (next_pos < 255) ? next_pos : 255;
            next_pos  = int'(min_pulse);
            if (next_neg < int'(min_pulse) + int'(dead_cnt))
              next_neg = int'(min_pulse) + int'(dead_cnt);
          end
        end
        next_held  = 1'b1;
        o.accepted = 1'b1;
      end
      o.driver_on = drv_level;
      return o;
    end

    // A tick hands out what the previous tick scheduled.
    o.q1   = edge_at[0];
    o.q2   = edge_at[1];
    o.q3   = edge_at[2];
    o.q4   = edge_at[3];
    o.tick = tick_at;

    // Any watched pin high in the first half, or a pattern that is not one
    // of the two diagonals, is a shoot-through risk.
    pins = it.port & PIN_MASK;
    if (pins != '0 && (!second_half || (pins != PIN_DIAG_A && pins != PIN_DIAG_B))) begin
      clear_bridge();
      o.fault     = 1'b1;
      o.driver_on = 1'b0;
      return o;
    end

    base = tick_at - 1'b1;
    foreach (edge_at[i]) edge_at[i] = base;
    hi = run_dir ? 2 : 0;

    if (second_half) begin
      if (next_held) begin
        run_dir   = next_dir;
        run_pos   = next_pos;
        run_neg   = next_neg;
        run_dith  = next_dith;
        next_held = 1'b0;
      end
      hi = run_dir ? 2 : 0;
      drv_level = motor_en;
      // The dither generator only steps when a cycle could switch at all.
      switching = 1'b0;
      if (motor_en && run_pos != 0) begin
        lsb = dither_reg[0];
        dither_reg = dither_reg >> 1;
        if (lsb) dither_reg = dither_reg ^ LFSR_TAPS;
        draw = (dither_reg[7:0] != 8'd0) ? dither_reg[7:0] : 8'd1;
        switching = (int'(draw) <= run_dith);
      end
      if (switching) begin
        edge_at[hi]     = tick_at + TIME_W'(half_gap(run_pos));
        edge_at[hi + 1] = tick_at + TIME_W'(half_gap(run_neg));
      end
      tick_at     = tick_at + TIME_W'(PWM_PERIOD / 2);
      second_half = 1'b0;
    end else begin
      if (switching) begin
        edge_at[hi]     = tick_at + TIME_W'(run_pos / 2);
        edge_at[hi + 1] = tick_at + TIME_W'(run_neg / 2);
      end
      tick_at     = tick_at + TIME_W'(PWM_PERIOD - PWM_PERIOD / 2);
      second_half = 1'b1;
    end

    o.driver_on = drv_level;
    return o;
  endfunction

  // ---------------------------------------------------------------------
  // Error reporting.
  // ---------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    $display("[%0t] %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [TIME_W-1:0] got, logic [TIME_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("result beat %0d, %s: got 0x%0h, expected 0x%0h",
                                results_seen, name, got, want));
  endtask

  // ---------------------------------------------------------------------
  // Clock.
  // ---------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Input driver. A beat that was accepted at this edge goes through the
  // checker's copy of the scheduler first; then the next beat is offered,
  // unless a random gap falls here. Beats 200 to 299 go out without gaps.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      item_bus.valid <= 1'b0;
    end else begin
      if (item_bus.valid && item_bus.ready) begin
        bridge_outputs_due.push_back(advance_bridge(in_flight));
        items_sent++;
      end
      if (!item_bus.valid || item_bus.ready) begin
        if (items_to_send.size() != 0 &&
            ((items_sent >= 200 && items_sent < 300) || $urandom_range(99) >= 25)) begin
          in_flight = items_to_send.pop_front();
          item_bus.op             <= in_flight.op;
          item_bus.command        <= in_flight.command;
          item_bus.supply_voltage <= in_flight.supply;
          item_bus.port_state     <= in_flight.port;
          item_bus.valid          <= 1'b1;
        end else begin
          item_bus.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver hold-off counter. Now and then ready stays low for a long
  // stretch so that the scheduler backs up to its input.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      hold_left    <= 0;
      next_hold_at <= 40;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (results_seen >= next_hold_at) begin
      hold_left    <= 400;
      next_hold_at <= next_hold_at + 350;
    end
  end

  // ---------------------------------------------------------------------
  // Result monitor. Every result beat is held against the oldest expected
  // one. Ready drops at random, never for results 200 to 299, and stays low
  // while a hold-off runs.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    bridge_out_t want;
    if (rst) begin
      result_bus.ready <= 1'b0;
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        if (bridge_outputs_due.size() == 0) begin
          report_mismatch($sformatf("result beat %0d arrived with nothing expected",
                                    results_seen));
        end else begin
          want = bridge_outputs_due.pop_front();
          check_field("accepted", result_bus.accepted, want.accepted);
          check_field("q1_compare", result_bus.q1_compare, want.q1);
          check_field("q2_compare", result_bus.q2_compare, want.q2);
          check_field("q3_compare", result_bus.q3_compare, want.q3);
          check_field("q4_compare", result_bus.q4_compare, want.q4);
          check_field("tick_compare", result_bus.tick_compare, want.tick);
          check_field("driver_on", result_bus.driver_on, want.driver_on);
          check_field("fault", result_bus.fault, want.fault);
        end
        results_seen++;
      end
      if (hold_left > 0) begin
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= (results_seen >= 200 && results_seen < 300) ||
                            ($urandom_range(99) >= 25);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------

  // A tick; the generator's phase follows the same fault rule as the block.
  task automatic add_tick(bit [PORT_W-1:0] port);
    drive_item_t     it;
    bit [PORT_W-1:0] pins;
    it.op      = OP_TICK;
    it.command = CMD_W'($urandom);
    it.supply  = SUP_W'($urandom);
    it.port    = port;
    items_to_send.push_back(it);
    items_queued++;
    pins = port & PIN_MASK;
    if (pins != '0 && (!gen_phase || (pins != PIN_DIAG_A && pins != PIN_DIAG_B)))
      gen_phase = 1'b0;
    else
      gen_phase = ~gen_phase;
  endtask

  // A tick whose watched pins are legal for the current half; the pins
  // that the block ignores carry random levels.
  task automatic add_legal_tick();
    bit [PORT_W-1:0] pins;
    pins = '0;
    if (gen_phase) begin
      case ($urandom_range(4))
        0:       pins = '0;
        1, 2:    pins = PIN_DIAG_A;
        default: pins = PIN_DIAG_B;
      endcase
    end
    add_tick((PORT_W'($urandom) & ~PIN_MASK) | pins);
  endtask

  task automatic add_command(bit [CMD_W-1:0] command, bit [SUP_W-1:0] supply);
    drive_item_t it;
    it.op      = OP_SET;
    it.command = command;
    it.supply  = supply;
    it.port    = PORT_W'($urandom);
    items_to_send.push_back(it);
    items_queued++;
  endtask

  // Demands: full-range values, magnitudes up to 17000 of either sign,
  // some of which end up as dithered minimum pulses, and the ends of the range.
  function automatic bit [CMD_W-1:0] random_demand();
    int mag;
    case ($urandom_range(3))
      0: begin
        mag = $urandom_range(17000);
        return $urandom_range(1) ? CMD_W'(-mag) : CMD_W'(mag);
      end
      1: begin
        case ($urandom_range(4))
          0:       return 16'h7FFF;
          1:       return 16'h8000;
          2:       return 16'h8001;
          3:       return 16'hFFFF;
          default: return 16'h0000;
        endcase
      end
      default: return CMD_W'($urandom);
    endcase
  endfunction

  // Supply readings either anywhere on the scale or close to nominal.
  function automatic bit [SUP_W-1:0] random_supply();
    int s;
    if ($urandom_range(1)) return SUP_W'($urandom);
    s = int'(nom_supply) + int'($urandom_range(600)) - 300;
    if (s < 0) s = 0;
    if (s > 4095) s = 4095;
    return SUP_W'(s);
  endfunction

  // Mostly well-formed tick streams with commands between them; a few
  // ticks carry random pins, which usually trips the fault path.
  task automatic random_items(int count);
    int r;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 25)
        add_command(random_demand(), random_supply());
      else if (r < 29)
        add_tick(PORT_W'($urandom));
      else
        add_legal_tick();
    end
  endtask

  // One register write; the checker's copy takes the value at the beat.
  task automatic cfg_write(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= index;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    case (index)
      CFG_BRIDGE_ENABLE:  motor_en   = data[0];
      CFG_NOMINAL_SUPPLY: nom_supply = data[SUP_W-1:0];
      CFG_DEAD_TIME:      dead_cnt   = data[DEAD_W-1:0];
      CFG_MIN_DUTY:       min_pulse  = data[MIN_W-1:0];
      default:            ;
    endcase
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic program_bridge(bit en, bit [SUP_W-1:0] nom, bit [DEAD_W-1:0] dead,
                                bit [MIN_W-1:0] minp);
    cfg_write(CFG_BRIDGE_ENABLE, CFG_DATA_W'(en));
    cfg_write(CFG_NOMINAL_SUPPLY, CFG_DATA_W'(nom));
    cfg_write(CFG_DEAD_TIME, CFG_DATA_W'(dead));
    cfg_write(CFG_MIN_DUTY, CFG_DATA_W'(minp));
  endtask

  // Every beat offered has been taken and every result has come back.
  task automatic wait_idle();
    while (!(items_sent == items_queued && bridge_outputs_due.size() == 0))
      @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Main sequence: reset, a directed opening, then random traffic under
  // several register settings. Registers change only while nothing is in
  // flight, so every result is predicted with the settings it ran under.
  // ---------------------------------------------------------------------
  initial begin
    motor_en   = 1'b0;
    nom_supply = NOMINAL_RESET;
    dead_cnt   = DEAD_RESET;
    min_pulse  = MIN_DUTY_RESET;
    clear_bridge();
    gen_phase  = 1'b0;

    item_bus.valid          = 1'b0;
    item_bus.op             = OP_SET;
    item_bus.command        = '0;
    item_bus.supply_voltage = '0;
    item_bus.port_state     = '0;
    result_bus.ready        = 1'b0;
    cfg_bus.valid           = 1'b0;
    cfg_bus.index           = CFG_BRIDGE_ENABLE;
    cfg_bus.data            = '0;

    rst = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Default timing with the driver allowed on.
    program_bridge(1'b1, NOMINAL_RESET, DEAD_RESET, MIN_DUTY_RESET);

    // Full positive demand below nominal supply, then a second command
    // while the first one is still pending, which must be dropped.
    add_command(16'h7FFF, 12'd1000);
    add_command(16'hFFFB, 12'd2000);
    // First half with ignored pins high, second half on each diagonal;
    // the pending command is latched here.
    add_tick(8'h39);
    add_tick(8'hC1);
    add_tick(8'h00);
    add_tick(8'h3E);
    // Most negative demand at the top of the supply scale.
    add_command(16'h8000, 12'd4095);
    add_tick(8'h00);
    add_tick(8'hC0);
    // A tiny demand with no supply reading: dithered minimum pulse.
    add_command(16'd40, 12'd0);
    repeat (4) add_tick(8'h00);
    // Zero demand, and the demand just above the most negative one.
    add_command(16'h0000, 12'd2000);
    add_tick(8'h00);
    add_tick(8'h06);
    add_command(16'h8001, NOMINAL_RESET);
    // Pin fault in the first half, then an illegal pattern in the second.
    add_tick(8'h02);
    add_tick(8'h00);
    add_tick(8'hC6);
    add_command(16'hFFFF, 12'd4095);
    add_tick(8'h00);
    add_tick(8'hC0);
    random_items(100);
    wait_idle();

    // Zero nominal supply wipes every duty but at a zero reading; widest dead time and minimum.
    program_bridge(1'b1, 12'd0, 8'd255, 10'd1023);
    random_items(60);
    wait_idle();

    // Driver off, no compensation, no dead time and no minimum.
    program_bridge(1'b0, 12'd4095, 8'd0, 10'd0);
    random_items(70);
    wait_idle();

    // Random settings.
    program_bridge(1'b1, SUP_W'($urandom), DEAD_W'($urandom), MIN_W'($urandom));
    random_items(110);
    wait_idle();

    // Pulses as long as the whole period.
    program_bridge(1'b1, 12'd2000, 8'd0, 10'd0);
    random_items(110);
    wait_idle();

    // Give a stray extra result beat time to show up.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("h_bridge_pwm_scheduler_test: clean");
    else
      $display("h_bridge_pwm_scheduler_test: errors");
    $finish;
  end

  // Watchdog: several times the slowest correct run, including the long
  // receiver hold-offs and the slowest command path on every beat.
  initial begin
    #2_000_000;
    $display("h_bridge_pwm_scheduler_test: errors");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/hbp_pkg.sv
rtl/hbp_item_if.sv
rtl/hbp_result_if.sv
rtl/hbp_cfg_if.sv
rtl/hbp_div.sv
rtl/h_bridge_pwm_scheduler.sv
verif/h_bridge_pwm_scheduler_test.sv
